// ===== rtl/mplh_pkg.sv =====
// Shared types and constants for the memory pressure level detector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mplh_pkg;

    // Field widths
    localparam int MB_W      = 20;
    localparam int LEVEL_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Level codes
    localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_LOW      = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_DEADLY   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_CRITICAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_DEADLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_CRITICAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAVE_DEADLY   = 3'd5;

    // Reset values of the thresholds
    localparam logic [MB_W-1:0] RST_ENTER_LOW      = 20'd25;
    localparam logic [MB_W-1:0] RST_ENTER_CRITICAL = 20'd20;
    localparam logic [MB_W-1:0] RST_ENTER_DEADLY   = 20'd19;
    localparam logic [MB_W-1:0] RST_LEAVE          = 20'd26;

    typedef struct packed {
        logic [MB_W-1:0] enter_low;
        logic [MB_W-1:0] enter_critical;
        logic [MB_W-1:0] enter_deadly;
        logic [MB_W-1:0] leave_low;
        logic [MB_W-1:0] leave_critical;
        logic [MB_W-1:0] leave_deadly;
    } thresh_t;

    typedef struct packed {
        logic [MB_W-1:0] reclaimable_mb;
        logic [MB_W-1:0] free_mb;
    } sample_t;

    typedef struct packed {
        logic               deadly_alert;
        logic               notify;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

// ===== rtl/mplh_cfg.sv =====
// Threshold register file for the memory pressure level detector.
// Depends on mplh_pkg.
`timescale 1ns / 1ps

module mplh_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mplh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mplh_pkg::MB_W-1:0]      cfg_data,
    output mplh_pkg::thresh_t              thresh
);
    import mplh_pkg::*;

    thresh_t thresh_reg;

    // Write one threshold per enabled cycle; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.enter_low      <= RST_ENTER_LOW;
            thresh_reg.enter_critical <= RST_ENTER_CRITICAL;
            thresh_reg.enter_deadly   <= RST_ENTER_DEADLY;
            thresh_reg.leave_low      <= RST_LEAVE;
            thresh_reg.leave_critical <= RST_LEAVE;
            thresh_reg.leave_deadly   <= RST_LEAVE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENTER_LOW:      thresh_reg.enter_low      <= cfg_data;
                REG_ENTER_CRITICAL: thresh_reg.enter_critical <= cfg_data;
                REG_ENTER_DEADLY:   thresh_reg.enter_deadly   <= cfg_data;
                REG_LEAVE_LOW:      thresh_reg.leave_low      <= cfg_data;
                REG_LEAVE_CRITICAL: thresh_reg.leave_critical <= cfg_data;
                REG_LEAVE_DEADLY:   thresh_reg.leave_deadly   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign thresh = thresh_reg;

endmodule

// ===== rtl/mplh_eval.sv =====
// Level decision with hysteresis and the stored last level.
// Depends on mplh_pkg.
`timescale 1ns / 1ps

module mplh_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  mplh_pkg::thresh_t  thresh,
    input  mplh_pkg::sample_t  sample,
    input  logic               advance,
    output mplh_pkg::result_t  result
);
    import mplh_pkg::*;

    logic [LEVEL_W-1:0] last_level_reg;
    logic [LEVEL_W-1:0] last_level_next;
    logic [LEVEL_W-1:0] cand;
    logic [LEVEL_W-1:0] level;
    logic [MB_W-1:0]    leave_th;
    logic               hold;

    // Highest level whose enter threshold lies above both values.
    always_comb
    begin
        if (sample.free_mb < thresh.enter_deadly &&
            sample.reclaimable_mb < thresh.enter_deadly)
            cand = LVL_DEADLY;
        else if (sample.free_mb < thresh.enter_critical &&
                 sample.reclaimable_mb < thresh.enter_critical)
            cand = LVL_CRITICAL;
        else if (sample.free_mb < thresh.enter_low &&
                 sample.reclaimable_mb < thresh.enter_low)
            cand = LVL_LOW;
        else
            cand = LVL_NORMAL;
    end

    // Leave threshold of the stored level.
    always_comb
    begin
        unique case (last_level_reg)
            LVL_LOW:      leave_th = thresh.leave_low;
            LVL_CRITICAL: leave_th = thresh.leave_critical;
            LVL_DEADLY:   leave_th = thresh.leave_deadly;
            default:      leave_th = '0;
        endcase
    end

    // Keep the stored level while both values stay below its leave threshold.
    assign hold  = (cand < last_level_reg) &&
                   (sample.free_mb < leave_th) && (sample.reclaimable_mb < leave_th);
    assign level = hold ? last_level_reg : cand;

    assign result.level        = level;
    assign result.deadly_alert = (level == LVL_DEADLY);
    assign result.notify       = (level != LVL_DEADLY) && (level != last_level_reg);

    // A deadly result leaves the stored level untouched.
    assign last_level_next = result.notify ? level : last_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_level_reg <= LVL_NORMAL;
        else if (advance)
            last_level_reg <= last_level_next;
    end

endmodule

// ===== rtl/memory_pressure_level_hysteresis.sv =====
// Top level of the memory pressure level detector with hysteresis.
// Depends on mplh_pkg, mplh_cfg and mplh_eval.
//
//   channel | signals                         | word contents (low bit up)
//   --------+---------------------------------+----------------------------------------
//   s       | s_tvalid s_tready s_tdata[39:0] | free_mb[19:0], reclaimable_mb[39:20]
//   m       | m_tvalid m_tready m_tdata[7:0]  | level[1:0], notify[2], deadly_alert[3]
//   cfg     | cfg_we cfg_index cfg_data       | one 20-bit threshold per write
//
// One word per cycle sustained while m does not stall. A word waits in the input
// register; its result is decided there in a single pass and lands in the result
// register, which drives m. The stored level moves only when a word passes to the
// result register. Reset clears both stages and restores the default thresholds;
// a stall on m backs up into s only once both registers are full.
`timescale 1ns / 1ps

module memory_pressure_level_hysteresis (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mplh_pkg::IN_DATA_W-1:0]  s_tdata,   // free_mb, reclaimable_mb
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mplh_pkg::OUT_DATA_W-1:0] m_tdata,   // level, notify, deadly_alert, pad
    input  logic                            cfg_we,
    input  logic [mplh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mplh_pkg::MB_W-1:0]       cfg_data
);
    import mplh_pkg::*;

    thresh_t thresh;
    sample_t sample_reg;
    result_t result;
    result_t result_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;

    mplh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh)
    );

    mplh_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .thresh  (thresh),
        .sample  (sample_reg),
        .advance (advance),
        .result  (result)
    );

    // A word moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            sample_reg <= sample_t'(s_tdata);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_reg};

endmodule

// ===== rtl/mplh_checker.sv =====
// Port-level checks for memory_pressure_level_hysteresis, bound to the top level.
// Depends on mplh_pkg.
`timescale 1ns / 1ps

module mplh_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mplh_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mplh_pkg::*;

    // A result held back by the sink keeps its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The alert flag goes with the deadly level and nothing else.
    a_alert_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[1:0] == LVL_DEADLY)))
        else $error("deadly_alert disagrees with level");

    // A deadly result never changes the stored level, so it never notifies.
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("notify and deadly_alert both set");

    // A drained output side never backs up the input side.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // No result straight out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind memory_pressure_level_hysteresis mplh_checker u_mplh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/mplh_level_checker.sv =====
// Checker for the memory pressure level detector: watches the sample, result
// and threshold channels, predicts every result word and compares it.
// Depends on mplh_pkg for field widths, level codes and register indexes.
`timescale 1ns / 1ps

module mplh_level_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mplh_pkg::IN_DATA_W-1:0]  s_tdata,   // free_mb, reclaimable_mb
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mplh_pkg::OUT_DATA_W-1:0] m_tdata,   // level, notify, deadly_alert, pad
    input  logic                            cfg_we,
    input  logic [mplh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mplh_pkg::MB_W-1:0]       cfg_data,
    output int                              mismatch_count,
    output int                              results_owed
);
    import mplh_pkg::*;

    // Thresholds indexed by level code; the normal entries stay zero and never decide a level.
    logic [MB_W-1:0]    enter_mb [4];
    logic [MB_W-1:0]    leave_mb [4];
    logic [LEVEL_W-1:0] held_level;
    result_t            owed_q [$];
    result_t            want;
    result_t            got;

    // Works out the result of one sample and moves the held level along.
    function automatic result_t judge_pressure(input sample_t smp);
        result_t            res;
        logic [LEVEL_W-1:0] cand;
        logic [MB_W-1:0]    bound;
        int                 k;

        // The highest level whose enter threshold lies above both values wins.
        cand = LVL_NORMAL;
        for (k = int'(LVL_DEADLY); k >= int'(LVL_LOW); k--)
        begin
            if (cand == LVL_NORMAL && smp.free_mb < enter_mb[k] &&
                smp.reclaimable_mb < enter_mb[k])
                cand = LEVEL_W'(k);
        end

        // Hysteresis: stay at the held level while both values are under its leave bound.
        bound = leave_mb[held_level];
        if (cand < held_level && smp.free_mb < bound && smp.reclaimable_mb < bound)
            cand = held_level;

        res.level        = cand;
        res.notify       = 1'b0;
        res.deadly_alert = 1'b0;
        if (cand == LVL_DEADLY)
            res.deadly_alert = 1'b1;
        else if (cand != held_level)
        begin
            held_level = cand;
            res.notify = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_mb[LVL_NORMAL]   = '0;
            enter_mb[LVL_LOW]      = RST_ENTER_LOW;
            enter_mb[LVL_CRITICAL] = RST_ENTER_CRITICAL;
            enter_mb[LVL_DEADLY]   = RST_ENTER_DEADLY;
            leave_mb[LVL_NORMAL]   = '0;
            leave_mb[LVL_LOW]      = RST_LEAVE;
            leave_mb[LVL_CRITICAL] = RST_LEAVE;
            leave_mb[LVL_DEADLY]   = RST_LEAVE;
            held_level             = LVL_NORMAL;
            owed_q.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            // Result side: compare against the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (owed_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word %h arrived with nothing expected",
                             $time, m_tdata);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.level !== want.level)
                    begin
                        mismatch_count++;
                        $display("%0t: level expected %0d, got %0d",
                                 $time, want.level, got.level);
                    end
                    if (got.notify !== want.notify)
                    begin
                        mismatch_count++;
                        $display("%0t: notify expected %0b, got %0b",
                                 $time, want.notify, got.notify);
                    end
                    if (got.deadly_alert !== want.deadly_alert)
                    begin
                        mismatch_count++;
                        $display("%0t: deadly_alert expected %0b, got %0b",
                                 $time, want.deadly_alert, got.deadly_alert);
                    end
                end
            end

            // Sample side: predict as soon as the word is taken.
            if (s_tvalid && s_tready)
                owed_q.push_back(judge_pressure(sample_t'(s_tdata)));

            // Threshold writes; indexes past the last register are dropped.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTER_LOW:      enter_mb[LVL_LOW]      = cfg_data;
                    REG_ENTER_CRITICAL: enter_mb[LVL_CRITICAL] = cfg_data;
                    REG_ENTER_DEADLY:   enter_mb[LVL_DEADLY]   = cfg_data;
                    REG_LEAVE_LOW:      leave_mb[LVL_LOW]      = cfg_data;
                    REG_LEAVE_CRITICAL: leave_mb[LVL_CRITICAL] = cfg_data;
                    REG_LEAVE_DEADLY:   leave_mb[LVL_DEADLY]   = cfg_data;
                    default:            ;
                endcase
            end

            results_owed = owed_q.size();
        end
    end

endmodule

// ===== test/memory_pressure_level_hysteresis_tb.sv =====
// Top of the testbench for the memory pressure level detector: drives samples,
// thresholds and result back-pressure, and reports the verdict.
// Depends on mplh_pkg, the block itself and mplh_level_checker.
`timescale 1ns / 1ps

module memory_pressure_level_hysteresis_tb;
    import mplh_pkg::*;

    localparam int                   CYCLE_LIMIT  = 400000;
    localparam logic [MB_W-1:0]      MB_MAX       = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // free_mb, reclaimable_mb
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // level, notify, deadly_alert, pad
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [MB_W-1:0]       cfg_data;
    int                    mismatch_count;
    int                    results_owed;
    int                    cycle_count = 0;

    // When set, neither side inserts gaps or stalls.
    bit                    calm;

    // Thresholds as currently written, used to aim samples near them.
    logic [MB_W-1:0]       cur_th [6];

    always #5 clk = ~clk;

    memory_pressure_level_hysteresis i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mplh_level_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Offers one sample word after a random gap and waits until it is taken.
    task automatic send_sample(input logic [MB_W-1:0] free_v, input logic [MB_W-1:0] recl_v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {recl_v, free_v};
        do @(posedge clk); while (!s_tready);
    endtask

    // Holds samples back until every predicted result has come out.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (results_owed == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MB_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_LEAVE_DEADLY)
            cur_th[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_thresholds(input logic [MB_W-1:0] e_low, input logic [MB_W-1:0] e_crit,
                                    input logic [MB_W-1:0] e_dead, input logic [MB_W-1:0] l_low,
                                    input logic [MB_W-1:0] l_crit, input logic [MB_W-1:0] l_dead);
        settle();
        write_reg(REG_ENTER_LOW, e_low);
        write_reg(REG_ENTER_CRITICAL, e_crit);
        write_reg(REG_ENTER_DEADLY, e_dead);
        write_reg(REG_LEAVE_LOW, l_low);
        write_reg(REG_LEAVE_CRITICAL, l_crit);
        write_reg(REG_LEAVE_DEADLY, l_dead);
    endtask

    // A value within four megabytes of a threshold, clamped to the field range.
    function automatic logic [MB_W-1:0] near_mb(input logic [MB_W-1:0] th);
        int v;
        v = int'(th) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > int'(MB_MAX))
            v = int'(MB_MAX);
        return v[MB_W-1:0];
    endfunction

    // Random samples, mostly straddling the thresholds so that levels move and hold.
    task automatic run_random(input int count);
        int              n;
        int              mode;
        logic [MB_W-1:0] th;
        logic [MB_W-1:0] free_v;
        logic [MB_W-1:0] recl_v;
        for (n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
                settle();
            mode = $urandom_range(0, 99);
            th   = cur_th[$urandom_range(0, 5)];
            if (mode < 60)
            begin
                free_v = near_mb(th);
                recl_v = near_mb(th);
            end
            else if (mode < 75)
            begin
                free_v = near_mb(th);
                recl_v = MB_W'($urandom);
                if ($urandom_range(0, 1))
                    {free_v, recl_v} = {recl_v, free_v};
            end
            else if (mode < 80)
            begin
                free_v = $urandom_range(0, 1) ? MB_MAX : '0;
                recl_v = $urandom_range(0, 1) ? MB_MAX : '0;
            end
            else
            begin
                free_v = MB_W'($urandom);
                recl_v = MB_W'($urandom);
            end
            send_sample(free_v, recl_v);
        end
        calm = 1'b0;
    endtask

    // Random back-pressure on the result channel.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [MB_W-1:0] th_set [6];
        int              p;
        int              r;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ENTER_LOW;
        cfg_data  = '0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        cur_th[REG_ENTER_LOW]      = RST_ENTER_LOW;
        cur_th[REG_ENTER_CRITICAL] = RST_ENTER_CRITICAL;
        cur_th[REG_ENTER_DEADLY]   = RST_ENTER_DEADLY;
        cur_th[REG_LEAVE_LOW]      = RST_LEAVE;
        cur_th[REG_LEAVE_CRITICAL] = RST_LEAVE;
        cur_th[REG_LEAVE_DEADLY]   = RST_LEAVE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk through every level and the hold band with the reset thresholds.
        send_sample(20'd100, 20'd100);
        send_sample(20'd24, 20'd24);
        send_sample(20'd25, 20'd24);
        send_sample(20'd26, 20'd0);
        send_sample(20'd19, 20'd19);
        send_sample(20'd18, 20'd18);
        send_sample(20'd18, 20'd30);
        send_sample(20'd0, 20'd0);
        send_sample(MB_MAX, MB_MAX);
        send_sample(20'd24, MB_MAX);
        send_sample(MB_MAX, 20'd0);
        send_sample(20'd22, 20'd21);
        send_sample(20'd22, 20'd21);
        send_sample(20'd20, 20'd20);
        send_sample(20'd19, 20'd1);
        send_sample(20'd25, 20'd25);
        send_sample(20'd24, 20'd24);
        send_sample(20'd26, 20'd26);
        run_random(220);

        // Ordered thresholds with a wide hold band.
        apply_thresholds(20'd1000, 20'd500, 20'd100, 20'd1200, 20'd700, 20'd300);
        run_random(260);

        // All thresholds at zero: nothing can enter or hold a level.
        apply_thresholds('0, '0, '0, '0, '0, '0);
        run_random(50);

        // All thresholds at the top: only the largest value stays out.
        apply_thresholds(MB_MAX, MB_MAX, MB_MAX, MB_MAX, MB_MAX, MB_MAX);
        run_random(70);

        // Unordered thresholds: deeper levels may be easier to enter.
        apply_thresholds(20'd100, 20'd5000, 20'd300, 20'd50, 20'd6000, 20'd20);
        run_random(240);

        // Leave bounds under the enter bounds, so the hold band is empty.
        apply_thresholds(20'd800, 20'd400, 20'd200, 20'd10, 20'd10, 20'd10);
        run_random(200);

        // Random threshold sets, mostly small so samples land near them.
        for (p = 0; p < 3; p++)
        begin
            foreach (th_set[i])
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    th_set[i] = MB_W'($urandom_range(0, 64));
                else if (r < 8)
                    th_set[i] = MB_W'($urandom_range(0, 4000));
                else
                    th_set[i] = MB_W'($urandom);
            end
            apply_thresholds(th_set[0], th_set[1], th_set[2],
                             th_set[3], th_set[4], th_set[5]);
            run_random(220);
        end

        // Writes past the last register, then the reset thresholds are written back in full.
        settle();
        write_reg(REG_SPARE_LO, MB_MAX);
        write_reg(REG_SPARE_HI, '0);
        apply_thresholds(RST_ENTER_LOW, RST_ENTER_CRITICAL, RST_ENTER_DEADLY,
                         RST_LEAVE, RST_LEAVE, RST_LEAVE);
        run_random(200);

        settle();
        @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
